@@ hdl/itsu_pkg.sv @@
// Package for the icosphere triangle subdivider: result kinds, modes, word widths.
// No dependencies.
package itsu_pkg;
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SUBDIV = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] KIND_MID    = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_LOADED = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    localparam int IDX_W = 10;
    localparam int OUT_C_W = 16;
endpackage

@@ hdl/itsu_divsqrt.sv @@
// Shared iterative unit: restoring integer square root and unsigned divide, one bit a cycle.
// Depends on nothing else.
module itsu_divsqrt #(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic         op_sqrt,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  num_reg, num_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sq_reg, sq_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  trial;
    logic [W+1:0]  shrem;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        num_next = num_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        sq_next = sq_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        shrem = '0;
        if (start) begin
            rem_next = '0;
            quo_next = '0;
            num_next = a_in;
            den_next = b_in;
            sq_next = op_sqrt;
            cnt_next = op_sqrt ? CW'(W / 2) : CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sq_reg) begin
                shrem = {rem_reg, num_reg[W-1:W-2]};
                trial = {quo_reg, 2'b01};
                num_next = {num_reg[W-3:0], 2'b00};
                if (shrem >= trial) begin
                    rem_next = W'(shrem - trial);
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = W'(shrem);
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
            end else begin
                shrem = {1'b0, rem_reg, num_reg[W-1]};
                trial = {2'b00, den_reg};
                num_next = {num_reg[W-2:0], 1'b0};
                if (shrem >= trial) begin
                    rem_next = W'(shrem - trial);
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = W'(shrem);
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
        den_reg <= den_next;
        sq_reg <= sq_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign result = quo_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(busy_reg)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |=> cnt_reg == $past(cnt_reg) - CW'(1) || !busy_reg)
        else $error("count slip");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done || $past(start)) else $error("done held");
`endif
endmodule

@@ hdl/icosphere_triangle_subdivider_unit.sv @@
// Top level of the icosphere triangle subdivider: sequencer, vertex store, edge cache.
// Depends on itsu_pkg and itsu_divsqrt.
//
//  channel | dir | tdata fields (low bit up)                               | tuser | tlast
//  s_      | in  | coord_x[15:0] coord_y[31:16] coord_z[47:32]             | mode  | -
//          |     | corner_first[57:48] second[67:58] third[77:68]         |       |
//  m_      | out | vertex_index[9:0] out_x[25:10] out_y[41:26] out_z[57:42]| kind  | last
//          |     | tri_a[67:58] tri_b[77:68] tri_c[87:78]                  |       |
//
// A load emits one output word; no new input is taken until that word has been accepted.
// A triangle searches the cache entry by entry for each edge; each new edge needs one
// 64-bit root (32 steps) and three 64-bit divides (64 steps each) on the shared
// divide/root unit and emits one midpoint word; four triangle words close the item.
// Reset is synchronous; both stores need no clearing pass. s_tready is low while
// an item is at work; a stalled m_ word holds.
module icosphere_triangle_subdivider_unit #(
    parameter int MAX_VERTS = 1024,
    parameter int CACHE_ENTRIES = 2048
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // coord_x, coord_y, coord_z, corner_first/second/third
    input  logic [1:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // vertex_index, out_x, out_y, out_z, tri_a, tri_b, tri_c
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast
);
    localparam int IW = itsu_pkg::IDX_W;
    localparam int VAW = $clog2(MAX_VERTS);
    localparam int VCW = $clog2(MAX_VERTS + 1);
    localparam int CAW = $clog2(CACHE_ENTRIES);
    localparam int CCW = $clog2(CACHE_ENTRIES + 1);
    localparam int CW = itsu_pkg::OUT_C_W;
    localparam int SW = CW + 1;
    localparam int H = (CW > 16) ? CW - 16 : 0;
    localparam int MW = SW - H;
    localparam int DW = 64;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_EDGE   = 13'b0000000000010,
        ST_SRCH   = 13'b0000000000100,
        ST_RDA    = 13'b0000000001000,
        ST_RDB    = 13'b0000000010000,
        ST_SUM    = 13'b0000000100000,
        ST_SQ     = 13'b0000001000000,
        ST_ROOT   = 13'b0000010000000,
        ST_DIV    = 13'b0000100000000,
        ST_STORE  = 13'b0001000000000,
        ST_EMIT   = 13'b0010000000000,
        ST_TRI    = 13'b0100000000000,
        ST_LOAD   = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic [1:0]    kind;
        logic [IW-1:0] idx;
        logic [15:0]   x, y, z;
        logic [IW-1:0] ta, tb, tc;
        logic          last;
    } word_t;

    state_t state_reg, state_next;

    logic [3*CW-1:0]      vmem [MAX_VERTS];
    logic [3*IW-1:0]      cmem [CACHE_ENTRIES];
    logic [3*CW-1:0]      vrd_reg;
    logic [3*IW-1:0]      crd_reg;
    logic [VCW-1:0]       vcnt_reg, vcnt_next;
    logic [CCW-1:0]       ccnt_reg, ccnt_next;
    logic [CCW-1:0]       sidx_reg, sidx_next;
    logic                 sfirst_reg, sfirst_next;

    logic [IW-1:0]        v_reg [3];
    logic [IW-1:0]        m_reg [3];
    logic [1:0]           e_reg, e_next;
    logic [1:0]           j_reg, j_next;
    logic [IW-1:0]        lo_reg, hi_reg;
    logic [3*CW-1:0]      va_reg;
    logic signed [SW-1:0] s_reg [3];
    logic [MW-1:0]        mg_reg [3];
    logic [DW-1:0]        l2_reg;
    logic [DW-1:0]        r_reg;
    logic [CW-1:0]        res_reg [3];
    logic                 work_reg;

    word_t                ow_reg, ow_next;
    logic                 ov_reg;
    logic                 out_ld;

    logic                 du_start, du_sqrt, du_busy, du_done;
    logic [DW-1:0]        du_a, du_b, du_res;

    logic [IW-1:0]        ea, eb;
    logic                 vwe, cwe;
    logic [VAW-1:0]       vwa, vra;
    logic [3*CW-1:0]      vwd;
    logic                 vra_ok;
    logic                 out_free;
    logic [2*MW-1:0]      sq;

    itsu_divsqrt #(.W(DW)) u_du (
        .aclk(aclk), .aresetn(aresetn), .start(du_start), .op_sqrt(du_sqrt),
        .a_in(du_a), .b_in(du_b), .busy(du_busy), .done(du_done), .result(du_res)
    );

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_ld = out_free &&
                    (state_reg == ST_LOAD || state_reg == ST_EMIT || state_reg == ST_TRI);

    function automatic logic [IW-1:0] edge_end(input logic [1:0] e, input logic first,
                                               input logic [IW-1:0] v0, input logic [IW-1:0] v1,
                                               input logic [IW-1:0] v2);
        logic [IW-1:0] r;
        case (e)
            2'd0:    r = first ? v0 : v1;
            2'd1:    r = first ? v1 : v2;
            default: r = first ? v2 : v0;
        endcase
        return r;
    endfunction

    assign ea = edge_end(e_reg, 1'b1, v_reg[0], v_reg[1], v_reg[2]);
    assign eb = edge_end(e_reg, 1'b0, v_reg[0], v_reg[1], v_reg[2]);

    always_comb begin
        vra = '0;
        vra_ok = 1'b0;
        if (state_reg == ST_SRCH || state_reg == ST_EDGE) begin
            vra = VAW'(ea);
            vra_ok = 32'(ea) < MAX_VERTS;
        end else begin
            vra = VAW'(eb);
            vra_ok = 32'(eb) < MAX_VERTS;
        end
    end

    logic vok_reg;
    always_ff @(posedge aclk) begin
        if (vwe) vmem[vwa] <= vwd;
        vrd_reg <= vmem[vra];
        vok_reg <= vra_ok;
        if (cwe) cmem[CAW'(ccnt_reg)] <= {IW'(vcnt_reg), hi_reg, lo_reg};
        crd_reg <= cmem[CAW'(sidx_reg)];
    end

    assign sq = mg_reg[j_reg] * mg_reg[j_reg];

    always_comb begin
        state_next = state_reg;
        vcnt_next = vcnt_reg;
        ccnt_next = ccnt_reg;
        sidx_next = sidx_reg;
        sfirst_next = sfirst_reg;
        e_next = e_reg;
        j_next = j_reg;
        vwe = 1'b0;
        vwa = VAW'(vcnt_reg);
        vwd = '0;
        cwe = 1'b0;
        du_start = 1'b0;
        du_sqrt = 1'b0;
        du_a = '0;
        du_b = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    e_next = '0;
                    case (s_tuser)
                        itsu_pkg::MODE_LOAD:   state_next = ST_LOAD;
                        itsu_pkg::MODE_SUBDIV: state_next = ST_EDGE;
                        itsu_pkg::MODE_CLEAR:  ccnt_next = '0;
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    if (32'(vcnt_reg) < MAX_VERTS) begin
                        vwe = 1'b1;
                        vwd = va_reg;
                        vcnt_next = vcnt_reg + VCW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EDGE: begin
                sidx_next = '0;
                sfirst_next = 1'b1;
                state_next = ST_SRCH;
            end
            ST_SRCH: begin
                sfirst_next = 1'b0;
                if (!sfirst_reg && crd_reg[IW-1:0] == lo_reg &&
                    crd_reg[2*IW-1:IW] == hi_reg && sidx_reg <= ccnt_reg &&
                    sidx_reg != '0) begin
                    e_next = (e_reg == 2'd2) ? e_reg : e_reg + 2'd1;
                    j_next = '0;
                    state_next = (e_reg == 2'd2) ? ST_TRI : ST_EDGE;
                end else if (sidx_reg >= ccnt_reg && !sfirst_reg || ccnt_reg == '0) begin
                    if (32'(vcnt_reg) >= MAX_VERTS) begin
                        j_next = '0;
                        state_next = (e_reg == 2'd2) ? ST_TRI : ST_EDGE;
                        e_next = (e_reg == 2'd2) ? e_reg : e_reg + 2'd1;
                    end else begin
                        state_next = ST_RDA;
                    end
                end else begin
                    sidx_next = sidx_reg + CCW'(1);
                end
            end
            ST_RDA: state_next = ST_RDB;
            ST_RDB: state_next = ST_SUM;
            ST_SUM: begin
                j_next = '0;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd2) begin
                    j_next = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (l2_reg == '0) begin
                    state_next = ST_STORE;
                end else if (!work_reg) begin
                    du_start = 1'b1;
                    du_sqrt = 1'b1;
                    du_a = l2_reg << 16;
                end else if (du_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!work_reg) begin
                    du_start = 1'b1;
                    du_a = (DW'(mg_reg[j_reg]) << (CW + 6)) + r_reg;
                    du_b = {r_reg[DW-2:0], 1'b0};
                end else if (du_done) begin
                    j_next = j_reg + 2'd1;
                    if (j_reg == 2'd2) begin
                        j_next = '0;
                        state_next = ST_STORE;
                    end
                end
            end
            ST_STORE: begin
                vwe = 1'b1;
                vwd = {res_reg[2], res_reg[1], res_reg[0]};
                vcnt_next = vcnt_reg + VCW'(1);
                if (32'(ccnt_reg) < CACHE_ENTRIES) begin
                    cwe = 1'b1;
                    ccnt_next = ccnt_reg + CCW'(1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    j_next = '0;
                    state_next = (e_reg == 2'd2) ? ST_TRI : ST_EDGE;
                    e_next = (e_reg == 2'd2) ? e_reg : e_reg + 2'd1;
                end
            end
            ST_TRI: begin
                if (out_free) begin
                    j_next = j_reg + 2'd1;
                    if (j_reg == 2'd3) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ow_next = '0;
        case (state_reg)
            ST_LOAD: begin
                ow_next.last = 1'b1;
                if (32'(vcnt_reg) < MAX_VERTS) begin
                    ow_next.kind = itsu_pkg::KIND_LOADED;
                    ow_next.idx = IW'(vcnt_reg);
                    ow_next.x = 16'($signed(va_reg[0 +: CW]));
                    ow_next.y = 16'($signed(va_reg[CW +: CW]));
                    ow_next.z = 16'($signed(va_reg[2*CW +: CW]));
                end else begin
                    ow_next.kind = itsu_pkg::KIND_FULL;
                end
            end
            ST_EMIT: begin
                ow_next.kind = itsu_pkg::KIND_MID;
                ow_next.idx = m_reg[e_reg];
                ow_next.x = 16'($signed(res_reg[0]));
                ow_next.y = 16'($signed(res_reg[1]));
                ow_next.z = 16'($signed(res_reg[2]));
            end
            ST_TRI: begin
                ow_next.kind = itsu_pkg::KIND_TRI;
                ow_next.last = (j_reg == 2'd3);
                case (j_reg)
                    2'd0: begin
                        ow_next.ta = v_reg[0]; ow_next.tb = m_reg[0]; ow_next.tc = m_reg[2];
                    end
                    2'd1: begin
                        ow_next.ta = v_reg[1]; ow_next.tb = m_reg[1]; ow_next.tc = m_reg[0];
                    end
                    2'd2: begin
                        ow_next.ta = v_reg[2]; ow_next.tb = m_reg[2]; ow_next.tc = m_reg[1];
                    end
                    default: begin
                        ow_next.ta = m_reg[0]; ow_next.tb = m_reg[1]; ow_next.tc = m_reg[2];
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vcnt_reg <= '0;
            ccnt_reg <= '0;
            ov_reg <= 1'b0;
            work_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            vcnt_reg <= vcnt_next;
            ccnt_reg <= ccnt_next;
            if (du_start) work_reg <= 1'b1;
            else if (du_done) work_reg <= 1'b0;
            if (out_ld) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
        sidx_reg <= sidx_next;
        sfirst_reg <= sfirst_next;
        e_reg <= e_next;
        j_reg <= j_next;
        if (state_reg == ST_IDLE && s_tvalid && s_tready) begin
            va_reg <= {s_tdata[32 +: CW], s_tdata[16 +: CW], s_tdata[0 +: CW]};
            v_reg[0] <= s_tdata[48 +: IW];
            v_reg[1] <= s_tdata[58 +: IW];
            v_reg[2] <= s_tdata[68 +: IW];
        end
        if (state_reg == ST_EDGE) begin
            lo_reg <= (ea < eb) ? ea : eb;
            hi_reg <= (ea < eb) ? eb : ea;
        end
        if (state_reg == ST_SRCH && !sfirst_reg && crd_reg[IW-1:0] == lo_reg &&
            crd_reg[2*IW-1:IW] == hi_reg && sidx_reg <= ccnt_reg && sidx_reg != '0)
            m_reg[e_reg] <= crd_reg[3*IW-1:2*IW];
        if (state_reg == ST_SRCH && (sidx_reg >= ccnt_reg && !sfirst_reg || ccnt_reg == '0)
            && 32'(vcnt_reg) >= MAX_VERTS && !(ccnt_reg != '0 && crd_reg[IW-1:0] == lo_reg
            && crd_reg[2*IW-1:IW] == hi_reg && sidx_reg <= ccnt_reg && sidx_reg != '0))
            m_reg[e_reg] <= '0;
        if (state_reg == ST_RDA) va_reg <= vok_reg ? vrd_reg : '0;
        if (state_reg == ST_RDB) begin
            for (int k = 0; k < 3; k++) begin
                s_reg[k] <= SW'($signed(va_reg[k*CW +: CW])) +
                            SW'($signed(vok_reg ? vrd_reg[k*CW +: CW] : CW'(0)));
            end
        end
        if (state_reg == ST_SUM) begin
            l2_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                mg_reg[k] <= MW'((s_reg[k] < 0 ? -s_reg[k] : s_reg[k]) >> H);
                res_reg[k] <= CW'(s_reg[k] / 2);
            end
        end
        if (state_reg == ST_SQ) l2_reg <= l2_reg + DW'(sq);
        if (state_reg == ST_ROOT && du_done) r_reg <= du_res;
        if (state_reg == ST_DIV && work_reg && du_done) begin
            if (du_res > DW'((1 << (CW - 1)) - 1))
                res_reg[j_reg] <= s_reg[j_reg] < 0 ? CW'(-(1 << (CW - 1))) :
                                                     CW'((1 << (CW - 1)) - 1);
            else
                res_reg[j_reg] <= s_reg[j_reg] < 0 ? CW'(-du_res) : CW'(du_res);
        end
        if (state_reg == ST_STORE) m_reg[e_reg] <= IW'(vcnt_reg);
        if (out_ld) ow_reg <= ow_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser = ow_reg.kind;
    assign m_tlast = ow_reg.last;
    assign m_tdata = {ow_reg.tc, ow_reg.tb, ow_reg.ta, ow_reg.z, ow_reg.y, ow_reg.x, ow_reg.idx};

`ifndef ASSERT_OFF
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready) else $error("ready while working");
    a_vcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(vcnt_reg) <= MAX_VERTS) else $error("vertex count overrun");
    a_ccnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ccnt_reg) <= CACHE_ENTRIES) else $error("cache count overrun");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("word dropped");
    a_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !du_busy) else $error("unit busy while idle");
`endif
endmodule
